[rtl/pedp_pkg.sv]
// shared types and codes for the parabolic ease distance profile
package pedp_pkg;

  // segment code reported with every result
  typedef enum logic [1:0] {
    SEG_ACCEL  = 2'd0,
    SEG_CRUISE = 2'd1,
    SEG_DECEL  = 2'd2
  } seg_t;

  // peak speed sequencer states
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_RUN
  } cs_state_t;

  // register index, taken from paddr[2]
  localparam logic REG_ACCEL_END   = 1'b0;
  localparam logic REG_DECEL_START = 1'b1;

endpackage

[rtl/parabolic_ease_distance_profile.sv]
// parabolic ease-in/ease-out distance profile, pipelined, with config registers
//
// Input beats carry a normalized time (unsigned, FRAC_BITS fraction bits) on
// in_sample_time; each gives one result beat with the distance travelled and
// the segment used (0 accelerating, 1 cruising, 2 decelerating).
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// A beat passes four arithmetic stages, a divider load stage, FRAC_BITS+2
// stages of a radix-2 divider (one quotient bit per stage), and the output
// register. Throughput is one beat per clock while out_stall is low and the
// peak speed divider is idle. When out_stall holds the output register the
// whole pipeline freezes, and a one-entry skid buffer still takes one more
// input beat before in_stall rises; nothing is lost or repeated.
// Registers accel_end (0x0) and decel_start (0x4) sit on an APB-style port;
// write them only while no beat is in flight. A write restarts the peak speed
// divider (a load step, then one quotient bit a cycle) with in_stall held
// high. After reset the registers hold 0.25 and 0.75, the same divider run
// computes the peak speed, and in_stall stays high until it ends.
module parabolic_ease_distance_profile #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FRAC_BITS:0]   in_sample_time,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FRAC_BITS:0]   out_distance,
  output logic [1:0]           out_segment,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int W   = FRAC_BITS + 1;        // field width
  localparam int VW  = FRAC_BITS + 2;        // speed, linear term
  localparam int DW  = FRAC_BITS + 2;        // divisor and remainder
  localparam int QW  = FRAC_BITS + 2;        // quotient bits
  localparam int MBW = W + 1;                // second square operand
  localparam int PW  = 2 * FRAC_BITS + 3;    // square product
  localparam int LW  = 2 * VW;               // linear product
  localparam int NW  = 2 * FRAC_BITS + 3;    // dividend
  localparam int SW  = VW + 1;               // final sum
  localparam int CNW = 2 * FRAC_BITS + 2;    // peak speed dividend
  localparam int CW  = $clog2(QW);

  localparam logic [W-1:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [MBW-1:0] TWO_ONE = {1'b1, {W{1'b0}}};
  localparam logic [W-1:0]   T1_RST  = ONE >> 2;
  localparam logic [W-1:0]   T2_RST  = ONE - (ONE >> 2);

  // configuration registers
  logic [W-1:0] accel_end_r;
  logic [W-1:0] decel_start_r;
  logic         cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pedp_pkg::REG_DECEL_START) ? 32'(decel_start_r)
                                                          : 32'(accel_end_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_end_r   <= T1_RST;
      decel_start_r <= T2_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == pedp_pkg::REG_DECEL_START) begin
        decel_start_r <= pwdata[W-1:0];
      end else begin
        accel_end_r <= pwdata[W-1:0];
      end
    end
  end

  // effective break points and config-only divisors
  logic [W-1:0]   t1;
  logic [W-1:0]   t2;
  logic [W-1:0]   span;
  logic [DW-1:0]  div_accel;
  logic [DW-1:0]  div_decel;
  logic [VW-1:0]  den;
  logic [CNW-1:0] cs_num;

  always_comb begin
    t1 = (accel_end_r > ONE) ? ONE : accel_end_r;
    t2 = (decel_start_r > ONE) ? ONE : decel_start_r;
    if (t2 < t1) begin
      t2 = t1;
    end
    span      = ONE - t2;
    div_accel = {t1, 1'b0};
    div_decel = {span, 1'b0};
    den       = VW'(ONE) - VW'(t1) + VW'(t2);
    cs_num    = (CNW'(1) << (2 * FRAC_BITS + 1)) + CNW'(den >> 1);
  end

  // peak speed sequencer: restoring divide, one bit a cycle
  pedp_pkg::cs_state_t cs_state_r, cs_state_nxt;
  logic [CW-1:0] cs_cnt_r, cs_cnt_nxt;
  logic [VW-1:0] cs_rem_r, cs_rem_nxt;
  logic [QW-1:0] cs_nq_r, cs_nq_nxt;
  logic [VW-1:0] cruise_speed_r, cruise_speed_nxt;
  logic [VW:0]   cs_trial;
  logic          cs_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_state_r <= pedp_pkg::CS_LOAD;
    end else begin
      cs_state_r <= cs_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cs_cnt_r       <= cs_cnt_nxt;
    cs_rem_r       <= cs_rem_nxt;
    cs_nq_r        <= cs_nq_nxt;
    cruise_speed_r <= cruise_speed_nxt;
  end

  always_comb begin
    cs_state_nxt     = cs_state_r;
    cs_cnt_nxt       = cs_cnt_r;
    cs_rem_nxt       = cs_rem_r;
    cs_nq_nxt        = cs_nq_r;
    cruise_speed_nxt = cruise_speed_r;
    cs_trial         = {cs_rem_r, cs_nq_r[QW-1]};
    cs_bit           = (cs_trial >= {1'b0, den});
    case (cs_state_r)
      pedp_pkg::CS_IDLE: begin
      end
      pedp_pkg::CS_LOAD: begin
        cs_rem_nxt   = VW'(cs_num >> QW);
        cs_nq_nxt    = cs_num[QW-1:0];
        cs_cnt_nxt   = '0;
        cs_state_nxt = pedp_pkg::CS_RUN;
      end
      pedp_pkg::CS_RUN: begin
        if (cs_bit) begin
          cs_rem_nxt = VW'(cs_trial - {1'b0, den});
        end else begin
          cs_rem_nxt = cs_trial[VW-1:0];
        end
        cs_nq_nxt  = {cs_nq_r[QW-2:0], cs_bit};
        cs_cnt_nxt = cs_cnt_r + 1'b1;
        if (cs_cnt_r == CW'(QW - 1)) begin
          cruise_speed_nxt = {cs_nq_r[QW-2:0], cs_bit};
          cs_state_nxt     = pedp_pkg::CS_IDLE;
        end
      end
      default: begin
        cs_state_nxt = pedp_pkg::CS_IDLE;
      end
    endcase
    // a register write always restarts the divide
    if (cfg_wr) begin
      cs_state_nxt = pedp_pkg::CS_LOAD;
    end
  end

  // input skid buffer and stall
  logic         en;
  logic         out_valid_r;
  logic         in_stall_r, in_stall_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  logic [W-1:0] skid_time_r;
  logic         in_acc;
  logic         src_valid;
  logic [W-1:0] src_time;

  assign en        = !out_valid_r || !out_stall;
  assign in_acc    = in_valid && !in_stall_r;
  assign src_valid = skid_valid_r || in_acc;
  assign src_time  = skid_valid_r ? skid_time_r : in_sample_time;
  assign in_stall  = in_stall_r;

  always_comb begin
    skid_valid_nxt = en ? 1'b0 : (skid_valid_r || in_acc);
    in_stall_nxt   = skid_valid_nxt || (cs_state_nxt != pedp_pkg::CS_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
      in_stall_r   <= 1'b1;
    end else begin
      skid_valid_r <= skid_valid_nxt;
      in_stall_r   <= in_stall_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_acc) begin
      skid_time_r <= in_sample_time;
    end
  end

  // stage 1: saturate time, pick segment, set up multiplier operands
  logic [W-1:0]     s1_time;
  pedp_pkg::seg_t   s1_seg;
  logic [W-1:0]     s1_ma;
  logic [MBW-1:0]   s1_mb;
  logic [VW-1:0]    s1_lc;
  logic             s1_full;

  always_comb begin
    s1_time = (src_time > ONE) ? ONE : src_time;
    s1_seg  = pedp_pkg::SEG_ACCEL;
    s1_ma   = s1_time;
    s1_mb   = MBW'(s1_time);
    s1_lc   = VW'({t2, 1'b0}) - VW'(t1);
    s1_full = 1'b0;
    if (s1_time <= t1) begin
      s1_seg = pedp_pkg::SEG_ACCEL;
    end else if (s1_time < t2) begin
      s1_seg = pedp_pkg::SEG_CRUISE;
      s1_lc  = VW'({s1_time, 1'b0}) - VW'(t1);
    end else begin
      s1_seg  = pedp_pkg::SEG_DECEL;
      s1_ma   = s1_time - t2;
      s1_mb   = TWO_ONE - MBW'(s1_time) - MBW'(t2);
      s1_full = (t2 == ONE);
    end
  end

  logic             p1_valid_r, p2_valid_r, p3_valid_r, p4_valid_r;
  pedp_pkg::seg_t   p1_seg_r, p2_seg_r, p3_seg_r, p4_seg_r;
  logic             p1_zero_r, p2_zero_r, p3_zero_r, p4_zero_r;
  logic             p1_full_r, p2_full_r, p3_full_r, p4_full_r;
  logic [W-1:0]     p1_ma_r;
  logic [MBW-1:0]   p1_mb_r;
  logic [VW-1:0]    p1_lc_r;
  logic [PW-1:0]    p2_sq_r;
  logic [LW-1:0]    p2_lin_r;
  logic [W-1:0]     p3_p_r;
  logic [VW-1:0]    p3_lin_r, p4_lin_r;
  logic [NW-1:0]    p4_vp_r;
  logic [PW-1:0]    sq_round;
  logic [LW-1:0]    lin_round;

  // divider stages, index 0 is the loaded dividend
  logic [QW:0]      dv_valid_r;
  logic [DW-1:0]    dv_rem_r  [QW+1];
  logic [QW-1:0]    dv_nq_r   [QW+1];
  pedp_pkg::seg_t   dv_seg_r  [QW+1];
  logic [VW-1:0]    dv_lin_r  [QW+1];
  logic             dv_zero_r [QW+1];
  logic             dv_full_r [QW+1];
  logic [DW-1:0]    dv_div    [QW];
  logic [DW:0]      dv_trial  [QW];
  logic [DW-1:0]    dv_rem_nxt [QW];
  logic [QW-1:0]    dv_nq_nxt  [QW];
  logic [NW-1:0]    dv_num;

  // rounding of the two products, and the dividend with its rounding bias
  always_comb begin
    sq_round  = p2_sq_r + PW'(ONE >> 1);
    lin_round = p2_lin_r + LW'(ONE);
    if (p4_seg_r == pedp_pkg::SEG_ACCEL) begin
      dv_num = p4_vp_r + NW'(t1);
    end else begin
      dv_num = p4_vp_r + NW'(span);
    end
  end

  // one quotient bit per divider stage
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      dv_div[k]   = (dv_seg_r[k] == pedp_pkg::SEG_ACCEL) ? div_accel : div_decel;
      dv_trial[k] = {dv_rem_r[k], dv_nq_r[k][QW-1]};
      if (dv_trial[k] >= {1'b0, dv_div[k]}) begin
        dv_rem_nxt[k] = DW'(dv_trial[k] - {1'b0, dv_div[k]});
        dv_nq_nxt[k]  = {dv_nq_r[k][QW-2:0], 1'b1};
      end else begin
        dv_rem_nxt[k] = dv_trial[k][DW-1:0];
        dv_nq_nxt[k]  = {dv_nq_r[k][QW-2:0], 1'b0};
      end
    end
  end

  // final combine and saturation
  logic [SW-1:0]  fin_sum;
  logic [W-1:0]   fin_dist;
  logic [W-1:0]   out_distance_r;
  pedp_pkg::seg_t out_segment_r;

  always_comb begin
    case (dv_seg_r[QW])
      pedp_pkg::SEG_CRUISE: begin
        fin_sum = SW'(dv_lin_r[QW]);
      end
      pedp_pkg::SEG_ACCEL: begin
        fin_sum = dv_zero_r[QW] ? '0 : SW'(dv_nq_r[QW]);
      end
      pedp_pkg::SEG_DECEL: begin
        fin_sum = dv_full_r[QW] ? SW'(ONE) : SW'(dv_nq_r[QW]) + SW'(dv_lin_r[QW]);
      end
      default: begin
        fin_sum = '0;
      end
    endcase
    fin_dist = (fin_sum > SW'(ONE)) ? ONE : fin_sum[W-1:0];
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      p4_valid_r  <= 1'b0;
      dv_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r  <= src_valid;
      p2_valid_r  <= p1_valid_r;
      p3_valid_r  <= p2_valid_r;
      p4_valid_r  <= p3_valid_r;
      dv_valid_r  <= {dv_valid_r[QW-1:0], p4_valid_r};
      out_valid_r <= dv_valid_r[QW];
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      p1_seg_r  <= s1_seg;
      p1_ma_r   <= s1_ma;
      p1_mb_r   <= s1_mb;
      p1_lc_r   <= s1_lc;
      p1_zero_r <= (t1 == '0);
      p1_full_r <= s1_full;
      // stage 2: square term and linear term
      p2_sq_r   <= PW'(p1_ma_r) * PW'(p1_mb_r);
      p2_lin_r  <= LW'(cruise_speed_r) * LW'(p1_lc_r);
      p2_seg_r  <= p1_seg_r;
      p2_zero_r <= p1_zero_r;
      p2_full_r <= p1_full_r;
      // stage 3: rounding
      p3_p_r    <= W'(sq_round >> FRAC_BITS);
      p3_lin_r  <= VW'(lin_round >> (FRAC_BITS + 1));
      p3_seg_r  <= p2_seg_r;
      p3_zero_r <= p2_zero_r;
      p3_full_r <= p2_full_r;
      // stage 4: scale by peak speed
      p4_vp_r   <= NW'(cruise_speed_r) * NW'(p3_p_r);
      p4_lin_r  <= p3_lin_r;
      p4_seg_r  <= p3_seg_r;
      p4_zero_r <= p3_zero_r;
      p4_full_r <= p3_full_r;
      // divider load
      dv_rem_r[0]  <= DW'(dv_num >> QW);
      dv_nq_r[0]   <= dv_num[QW-1:0];
      dv_seg_r[0]  <= p4_seg_r;
      dv_lin_r[0]  <= p4_lin_r;
      dv_zero_r[0] <= p4_zero_r;
      dv_full_r[0] <= p4_full_r;
      // divider steps
      for (int k = 0; k < QW; k++) begin
        dv_rem_r[k+1]  <= dv_rem_nxt[k];
        dv_nq_r[k+1]   <= dv_nq_nxt[k];
        dv_seg_r[k+1]  <= dv_seg_r[k];
        dv_lin_r[k+1]  <= dv_lin_r[k];
        dv_zero_r[k+1] <= dv_zero_r[k];
        dv_full_r[k+1] <= dv_full_r[k];
      end
      // output register
      out_distance_r <= fin_dist;
      out_segment_r  <= dv_seg_r[QW];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_segment  = out_segment_r;

`ifndef ASSERT_OFF
  // no beat enters while the peak speed is being recomputed
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cs_state_r == pedp_pkg::CS_IDLE))
    else $error("input beat accepted while peak speed divider busy");

  // a held skid entry must keep the input stalled
  a_skid_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> in_stall_r)
    else $error("skid buffer full without input stall");

  // results are saturated to one
  a_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_distance_r <= ONE))
    else $error("distance above one");

  // a register write restarts the divider
  a_wr_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (cs_state_r == pedp_pkg::CS_LOAD))
    else $error("register write did not restart peak speed divide");

  // peak speed stays at or below two once computed
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cs_state_r == pedp_pkg::CS_IDLE) |-> (cruise_speed_r <= VW'({ONE, 1'b0})))
    else $error("peak speed above two");
`endif

endmodule

[test/pedp_distance_checker.sv]
// watches both channels and the register port, predicts each distance beat and compares
module pedp_distance_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [FRAC_BITS:0] in_sample_time,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [FRAC_BITS:0] out_distance,
  input  logic [1:0]         out_segment,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_beats
);

  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

  typedef struct packed {
    logic [FRAC_BITS:0] distance;
    pedp_pkg::seg_t     seg;
  } ease_beat_t;

  // own copy of the registers and the derived peak speed
  logic [FRAC_BITS:0] accel_end_r;
  logic [FRAC_BITS:0] decel_start_r;
  longint unsigned    peak_speed;
  ease_beat_t         distance_q[$];

  function automatic longint unsigned clip_unit(input longint unsigned x);
    return (x > ONE) ? ONE : x;
  endfunction

  // registers clipped to 1.0, decel point never ahead of accel point
  function automatic void knee_points(output longint unsigned t1, output longint unsigned t2);
    t1 = clip_unit(longint'(accel_end_r));
    t2 = clip_unit(longint'(decel_start_r));
    if (t2 < t1) t2 = t1;
  endfunction

  // peak speed 2/(1 - t1 + t2), rounded half up
  function automatic longint unsigned speed_for_knees();
    longint unsigned t1, t2, den;
    knee_points(t1, t2);
    den = ONE - t1 + t2;
    return (((ONE * ONE) << 1) + den / 2) / den;
  endfunction

  function automatic ease_beat_t ease_distance(input logic [FRAC_BITS:0] raw);
    longint unsigned t1, t2, t, v, d, p, span, q, ramp, base;
    ease_beat_t r;
    knee_points(t1, t2);
    t = clip_unit(longint'(raw));
    v = peak_speed;
    if (t <= t1) begin
      // speeding up: distance grows with t squared
      r.seg = pedp_pkg::SEG_ACCEL;
      if (t1 == 0) begin
        d = 0;
      end else begin
        p = (t * t + (ONE >> 1)) >> FRAC_BITS;
        d = (v * p + t1) / (2 * t1);
      end
    end else if (t < t2) begin
      r.seg = pedp_pkg::SEG_CRUISE;
      d = (v * (2 * t - t1) + ONE) >> (FRAC_BITS + 1);
    end else begin
      // slowing down: distance at t2 plus the decel parabola
      r.seg = pedp_pkg::SEG_DECEL;
      if (t2 == ONE) begin
        d = ONE;
      end else begin
        span = ONE - t2;
        q = ((t - t2) * (2 * ONE - t - t2) + (ONE >> 1)) >> FRAC_BITS;
        ramp = (v * q + span) / (2 * span);
        base = (v * (2 * t2 - t1) + ONE) >> (FRAC_BITS + 1);
        d = ramp + base;
      end
    end
    d = clip_unit(d);
    r.distance = d[FRAC_BITS:0];
    return r;
  endfunction

  always @(posedge clk) begin
    ease_beat_t want;
    logic [FRAC_BITS:0] reg_val;
    if (!rst_n) begin
      accel_end_r   = ONE >> 2;
      decel_start_r = 3 * (ONE >> 2);
      peak_speed    = speed_for_knees();
      distance_q.delete();
    end else begin
      // register port: writes update the model, reads are checked
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == pedp_pkg::REG_ACCEL_END) accel_end_r = pwdata[FRAC_BITS:0];
          else accel_end_r = accel_end_r;
          if (paddr[2] == pedp_pkg::REG_DECEL_START) decel_start_r = pwdata[FRAC_BITS:0];
          peak_speed = speed_for_knees();
        end else begin
          reg_val = (paddr[2] == pedp_pkg::REG_ACCEL_END) ? accel_end_r : decel_start_r;
          if (prdata !== 32'(reg_val)) begin
            $display("%0t: register read mismatch at 0x%0h, expected %0d, got %0d",
                     $time, paddr, reg_val, prdata);
            fail_count++;
          end
        end
      end
      // input beat taken: queue its distance
      if (in_valid && !in_stall) distance_q.push_back(ease_distance(in_sample_time));
      // result beat taken: compare with the oldest queued distance
      if (out_valid && !out_stall) begin
        if (distance_q.size() == 0) begin
          $display("%0t: result beat with nothing queued, got distance %0d segment %0d",
                   $time, out_distance, out_segment);
          fail_count++;
        end else begin
          want = distance_q.pop_front();
          if (out_distance !== want.distance) begin
            $display("%0t: distance mismatch, expected %0d, got %0d",
                     $time, want.distance, out_distance);
            fail_count++;
          end
          if (out_segment !== want.seg) begin
            $display("%0t: segment mismatch, expected %0d, got %0d",
                     $time, want.seg, out_segment);
            fail_count++;
          end
        end
      end
    end
    pending_beats = distance_q.size();
  end

endmodule

[test/tb.sv]
// stimulus and verdict for the parabolic ease distance profile
module tb;

  localparam int FRAC_BITS = 16;
  localparam logic [FRAC_BITS:0] UNIT = 17'h10000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [FRAC_BITS:0] in_sample_time;
  logic               out_valid;
  logic               out_stall;
  logic [FRAC_BITS:0] out_distance;
  logic [1:0]         out_segment;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending_beats;

  // no gaps on either side while set
  bit                 quiet_gaps;
  // current register contents, used to aim samples near the knees
  logic [FRAC_BITS:0] accel_now;
  logic [FRAC_BITS:0] decel_now;

  parabolic_ease_distance_profile #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_sample_time,
    .out_valid, .out_stall, .out_distance, .out_segment,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pedp_distance_checker #(.FRAC_BITS(FRAC_BITS)) u_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_sample_time,
    .out_valid, .out_stall, .out_distance, .out_segment,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .pending_beats
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stall before each beat
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = quiet_gaps ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // one beat on the input channel, entered and left at a falling edge
  task automatic send_sample(input logic [FRAC_BITS:0] t);
    int gap;
    gap = quiet_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_sample_time = t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // setup and access cycle on the register port
  task automatic apb_access(input logic wr, input logic sel_reg, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {sel_reg, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // wait until every queued result is out and the pipeline has drained
  task automatic drain();
    in_valid = 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (FRAC_BITS + 12) @(negedge clk);
  endtask

  // reprogram both knees while idle, then read them back
  task automatic set_profile(input logic [31:0] a_word, input logic [31:0] b_word);
    drain();
    apb_access(1'b1, pedp_pkg::REG_ACCEL_END, a_word);
    apb_access(1'b1, pedp_pkg::REG_DECEL_START, b_word);
    accel_now = a_word[FRAC_BITS:0];
    decel_now = b_word[FRAC_BITS:0];
    apb_access(1'b0, pedp_pkg::REG_ACCEL_END, 32'd0);
    apb_access(1'b0, pedp_pkg::REG_DECEL_START, 32'd0);
  endtask

  // knee value: extremes, beyond 1.0, tiny, or anywhere, some with junk upper bits
  function automatic logic [31:0] pick_knee();
    logic [31:0] w;
    logic [31:0] junk;
    case ($urandom_range(0, 7))
      0:       w = 32'd0;
      1:       w = 32'(UNIT);
      2:       w = $urandom_range(32'h10001, 32'h1ffff);
      3:       w = $urandom_range(0, 8);
      default: w = $urandom_range(0, 32'h10000);
    endcase
    junk = $urandom;
    if ($urandom_range(0, 3) == 0) w[31:FRAC_BITS+1] = junk[31:FRAC_BITS+1];
    return w;
  endfunction

  // sample time: mostly in range, some beyond 1.0, some right at the knees
  function automatic logic [FRAC_BITS:0] pick_time();
    int t1, t2, k;
    t1 = (accel_now > UNIT) ? int'(UNIT) : int'(accel_now);
    t2 = (decel_now > UNIT) ? int'(UNIT) : int'(decel_now);
    if (t2 < t1) t2 = t1;
    case ($urandom_range(0, 9))
      5:       k = $urandom_range(0, 32'h1ffff);
      6:       k = t1 + $urandom_range(0, 4) - 2;
      7:       k = t2 + $urandom_range(0, 4) - 2;
      8:       k = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(65534, 65536);
      9:       k = $urandom_range(65530, 65542);
      default: k = $urandom_range(0, 32'h10000);
    endcase
    if (k < 0) k = 0;
    return k[FRAC_BITS:0];
  endfunction

  initial begin
    logic [31:0] ka, kb, kt;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample_time = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    quiet_gaps     = 1'b0;
    accel_now      = 17'd16384;
    decel_now      = 17'd49152;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset knees at 0.25 and 0.75: read back, then walk every segment and its edges
    apb_access(1'b0, pedp_pkg::REG_ACCEL_END, 32'd0);
    apb_access(1'b0, pedp_pkg::REG_DECEL_START, 32'd0);
    send_sample(17'd0);
    send_sample(17'd1);
    send_sample(17'd16384);
    send_sample(17'd16385);
    send_sample(17'd49151);
    send_sample(17'd49152);
    send_sample(17'd65535);
    send_sample(UNIT);
    send_sample(17'h1ffff);

    // zero accel_end: time 0 gives distance 0
    set_profile(32'd0, 32'd49152);
    send_sample(17'd0);
    send_sample(17'd1);
    send_sample(UNIT);

    // decel_start at 1.0: time 1.0 gives full distance
    set_profile(32'd0, 32'(UNIT));
    send_sample(UNIT);
    send_sample(17'd65535);
    send_sample(17'h10001);

    // accel_end beyond 1.0 and above decel_start
    set_profile(32'h0001_ffff, 32'd20000);
    send_sample(17'd0);
    send_sample(17'd65535);
    send_sample(17'd100000);

    // accel_end above decel_start: no cruise segment
    set_profile(32'd40000, 32'd20000);
    send_sample(17'd20000);
    send_sample(17'd40000);
    send_sample(17'd40001);
    send_sample(17'd65535);

    // random phases, each with its own knees
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin
          ka = 32'd0;
          kb = 32'd0;
        end
        1: begin
          ka = 32'(UNIT);
          kb = 32'(UNIT);
        end
        default: begin
          ka = pick_knee();
          kb = pick_knee();
          if ($urandom_range(0, 4) != 0 && ka[FRAC_BITS:0] > kb[FRAC_BITS:0]) begin
            kt = ka;
            ka = kb;
            kb = kt;
          end
        end
      endcase
      set_profile(ka, kb);
      quiet_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 136; i++) send_sample(pick_time());
      quiet_gaps = 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
